>>> design/q16_fixed_point_alu_assert.svh
// Assertion macros for the Q16.16 arithmetic unit.
// Expects the including module to have i_clk and i_rst_n in scope.
`ifndef Q16_FIXED_POINT_ALU_ASSERT_SVH
`define Q16_FIXED_POINT_ALU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define Q16A_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define Q16A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/q16alu_pkg.sv
// Shared types, operation codes and constants of the Q16.16 arithmetic unit.
// No dependencies; imported by q16_fixed_point_alu.
package q16alu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CNT_W      = $clog2(DATA_W);
    localparam int POS_W      = 6;
    localparam int TYPE_W     = 3;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // Request types.
    localparam logic [TYPE_W-1:0] OP_ADD      = 3'd0;
    localparam logic [TYPE_W-1:0] OP_SUB      = 3'd1;
    localparam logic [TYPE_W-1:0] OP_MUL      = 3'd2;
    localparam logic [TYPE_W-1:0] OP_DIV      = 3'd3;
    localparam logic [TYPE_W-1:0] OP_MIN      = 3'd4;
    localparam logic [TYPE_W-1:0] OP_MAX      = 3'd5;
    localparam logic [TYPE_W-1:0] OP_FROM_INT = 3'd6;
    localparam logic [TYPE_W-1:0] OP_TO_INT   = 3'd7;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIVZ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVF   = 1'b1;

    localparam logic [DATA_W-1:0] OVF_VALUE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] DIVZ_VALUE = 32'h8000_0000;
    localparam logic [DATA_W-1:0] KICK_MASK  = 32'hFFF0_0000;
    localparam logic [DATA_W-1:0] HALF_LSB   = 32'h0000_8000;

    typedef struct packed {
        logic [TYPE_W-1:0]        req_type;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [STAT_W-1:0]        status;
    } t_rsp;

    // Unsigned magnitude; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

endpackage

>>> design/q16_fixed_point_alu.sv
// Top level of the Q16.16 arithmetic unit: sequencer, shared add/subtract unit, outputs.
// Depends on q16alu_pkg and q16_fixed_point_alu_assert.svh.
//
// Usage: drive i_req and raise start while busy is low; the request is taken at that
// clock edge. Each request yields exactly one response on o_rsp, marked by o_done for
// a single cycle; the receiver must take it then, as there is no back-pressure.
// Add, sub, min, max, from_int and to_int answer in the cycle after acceptance and
// leave busy low, so they can be issued every cycle.
// Multiply runs 32 shift-add steps on the shared 33-bit adder, then a sign fix and an
// overflow check, plus a rounding increment when rounding is enabled.
// Divide by zero answers in the next cycle. Other divides take an optional kick-start
// (32 divide steps plus 32 multiply steps) and then one restoring division per
// quotient digit, up to 18 digits, plus up to 17 normalizing shifts. The shared
// adder does one bit per cycle.
// Busy stays high from acceptance until the cycle o_done is raised.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at once and
// belong in idle time. Reset is synchronous: the unit returns to idle, no response is
// pending, and rounding and overflow checking are both enabled.
`include "q16_fixed_point_alu_assert.svh"

module q16_fixed_point_alu (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  q16alu_pkg::t_req                   i_req,
    output logic                               busy,
    output logic                               o_done,
    output q16alu_pkg::t_rsp                   o_rsp,
    input  logic                               i_cfg_we,
    input  logic [q16alu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [q16alu_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import q16alu_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_MFIX  = 4'd2;
    localparam logic [3:0] S_MRND  = 4'd3;
    localparam logic [3:0] S_MINC  = 4'd4;
    localparam logic [3:0] S_DPRE  = 4'd5;
    localparam logic [3:0] S_KDIV  = 4'd6;
    localparam logic [3:0] S_KMUL  = 4'd7;
    localparam logic [3:0] S_KSUB  = 4'd8;
    localparam logic [3:0] S_NIB   = 4'd9;
    localparam logic [3:0] S_LOOP  = 4'd10;
    localparam logic [3:0] S_NORM  = 4'd11;
    localparam logic [3:0] S_DSTEP = 4'd12;
    localparam logic [3:0] S_ACC   = 4'd13;
    localparam logic [3:0] S_RND   = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);
    localparam logic [POS_W-1:0] POS_INIT = POS_W'(FRAC_BITS + 1);
    localparam int               TOP_LO   = 3 * FRAC_BITS - 1;
    localparam int               RND_W    = DATA_W + FRAC_BITS;

    // Control registers.
    logic [3:0]       r_state, n_state;
    logic             r_done, n_done;
    logic             r_round, r_ovf_chk;

    // Datapath registers.
    logic [DATA_W:0]   r_hi, n_hi;
    logic [DATA_W-1:0] r_lo, n_lo;
    logic [DATA_W-1:0] r_opnd, n_opnd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvr, n_dvr;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_neg, n_neg;
    logic [PROD_W-1:0] r_prod, n_prod;
    t_rsp              r_rsp, n_rsp;

    // Request operands as plain vectors.
    logic [DATA_W-1:0] op_a, op_b, mag_a, mag_b;
    logic [DATA_W:0]   ti_sum;

    // Shared adder and the step results built on it.
    logic              alu_div;
    logic [DATA_W:0]   alu_x, alu_y;
    logic [DATA_W+1:0] alu_sum;
    logic [DATA_W:0]   div_hi, mul_acc, mul_hi;
    logic [DATA_W-1:0] div_lo, mul_lo;

    // Finishing logic for multiply and divide.
    logic [PROD_W-1:0]       prod_mag;
    logic [PROD_W-1-TOP_LO:0] prod_top;
    logic                    mul_ovf;
    logic [RND_W-1:0]        rnd_t;
    logic [DATA_W-1:0]       digit_sh, digit_mask, quo_half;
    logic                    digit_ovf;

    // Handshake terms used by the checks.
    logic              req_take, req_quick, req_mul;
    logic              rsp_ovf, rsp_divz;

    assign op_a  = i_req.operand_a;
    assign op_b  = i_req.operand_b;
    assign mag_a = mag32(op_a);
    assign mag_b = mag32(op_b);

    // To_int rounds half away from zero with one signed add: +0x8000 for positive
    // values, +0x7FFF for negative ones, then an arithmetic shift.
    assign ti_sum = {op_a[DATA_W-1], op_a}
                  + (op_a[DATA_W-1] ? ((DATA_W+1)'(HALF_LSB) - (DATA_W+1)'(1))
                                    : (DATA_W+1)'(HALF_LSB));

    // The shared unit subtracts for a restoring divide step and adds for a multiply step.
    assign alu_div = (r_state == S_KDIV) || (r_state == S_DSTEP);
    assign alu_x   = alu_div ? {r_hi[DATA_W-1:0], r_lo[DATA_W-1]} : r_hi;
    assign alu_y   = {1'b0, r_opnd};
    assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_div ? ~alu_y : alu_y)}
                   + (DATA_W+2)'(alu_div);

    // Divide step: keep the trial difference when there is no borrow.
    assign div_hi = alu_sum[DATA_W+1] ? alu_sum[DATA_W:0] : alu_x;
    assign div_lo = {r_lo[DATA_W-2:0], alu_sum[DATA_W+1]};

    // Multiply step: conditional add, then shift the pair right.
    assign mul_acc = r_lo[0] ? alu_sum[DATA_W:0] : r_hi;
    assign mul_hi  = {1'b0, mul_acc[DATA_W:1]};
    assign mul_lo  = {mul_acc[0], r_lo[DATA_W-1:1]};

    assign prod_mag = {r_hi[DATA_W-1:0], r_lo};
    assign prod_top = r_prod[PROD_W-1:TOP_LO];
    assign mul_ovf  = r_ovf_chk && !((&prod_top) || !(|prod_top));
    assign rnd_t    = r_prod[RND_W-1:0] - RND_W'(HALF_LSB) - RND_W'(r_prod[PROD_W-1]);

    // Quotient digit placement and its fit check at the current bit position.
    assign digit_sh   = r_lo << r_pos[4:0];
    assign digit_mask = ~({DATA_W{1'b1}} >> r_pos[4:0]);
    assign digit_ovf  = r_ovf_chk && (|(r_lo & digit_mask));
    assign quo_half   = r_quo >> 1;

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_opnd  = r_opnd;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvr   = r_dvr;
        n_quo   = r_quo;
        n_pos   = r_pos;
        n_neg   = r_neg;
        n_prod  = r_prod;
        n_rsp   = r_rsp;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_neg        = op_a[DATA_W-1] ^ op_b[DATA_W-1];
                    n_rsp.status = ST_OK;
                    unique case (i_req.req_type)
                        OP_ADD: begin
                            n_done       = 1'b1;
                            n_rsp.result = op_a + op_b;
                        end
                        OP_SUB: begin
                            n_done       = 1'b1;
                            n_rsp.result = op_a - op_b;
                        end
                        OP_MIN: begin
                            n_done       = 1'b1;
                            n_rsp.result = (i_req.operand_a < i_req.operand_b) ? op_a : op_b;
                        end
                        OP_MAX: begin
                            n_done       = 1'b1;
                            n_rsp.result = (i_req.operand_a > i_req.operand_b) ? op_a : op_b;
                        end
                        OP_FROM_INT: begin
                            n_done       = 1'b1;
                            n_rsp.result = op_a << FRAC_BITS;
                        end
                        OP_TO_INT: begin
                            n_done       = 1'b1;
                            n_rsp.result = {{(FRAC_BITS-1){ti_sum[DATA_W]}},
                                            ti_sum[DATA_W:FRAC_BITS]};
                        end
                        OP_MUL: begin
                            n_hi    = '0;
                            n_lo    = mag_a;
                            n_opnd  = mag_b;
                            n_cnt   = '0;
                            n_state = S_MUL;
                        end
                        OP_DIV: begin
                            if (op_b == '0) begin
                                n_done       = 1'b1;
                                n_rsp.result = DIVZ_VALUE;
                                n_rsp.status = ST_DIVZ;
                            end else begin
                                n_rem   = mag_a;
                                n_dvr   = mag_b;
                                n_quo   = '0;
                                n_pos   = POS_INIT;
                                n_state = S_DPRE;
                            end
                        end
                    endcase
                end
            end

            // Unsigned shift-add multiply of the magnitudes.
            S_MUL: begin
                n_hi  = mul_hi;
                n_lo  = mul_lo;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_MFIX;
                end
            end

            // Apply the product sign.
            S_MFIX: begin
                n_prod  = r_neg ? (PROD_W'(0) - prod_mag) : prod_mag;
                n_state = S_MRND;
            end

            // Overflow check on the top bits, then truncate or start rounding.
            S_MRND: begin
                if (mul_ovf) begin
                    n_done       = 1'b1;
                    n_rsp.result = OVF_VALUE;
                    n_rsp.status = ST_OVF;
                    n_state      = S_IDLE;
                end else if (!r_round) begin
                    n_done       = 1'b1;
                    n_rsp.result = r_prod[RND_W-1:FRAC_BITS];
                    n_rsp.status = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_quo   = rnd_t[RND_W-1:FRAC_BITS];
                    n_state = S_MINC;
                end
            end

            S_MINC: begin
                n_done       = 1'b1;
                n_rsp.result = r_quo + DATA_W'(1);
                n_rsp.status = ST_OK;
                n_state      = S_IDLE;
            end

            // Large divisors get a coarse first quotient from a reduced divisor.
            S_DPRE: begin
                if (|(r_dvr & KICK_MASK)) begin
                    n_hi    = '0;
                    n_lo    = r_rem;
                    n_opnd  = (r_dvr >> (FRAC_BITS + 1)) + DATA_W'(1);
                    n_cnt   = '0;
                    n_state = S_KDIV;
                end else begin
                    n_state = S_NIB;
                end
            end

            S_KDIV: begin
                n_hi  = div_hi;
                n_lo  = div_lo;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    // Quotient is ready; multiply it back by the full divisor.
                    n_quo   = div_lo;
                    n_hi    = '0;
                    n_opnd  = r_dvr;
                    n_state = S_KMUL;
                end
            end

            S_KMUL: begin
                n_hi  = mul_hi;
                n_lo  = mul_lo;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_KSUB;
                end
            end

            S_KSUB: begin
                n_rem   = r_rem - prod_mag[FRAC_BITS+1 +: DATA_W];
                n_state = S_NIB;
            end

            // Strip trailing zero nibbles of the divisor.
            S_NIB: begin
                if ((r_dvr[3:0] == 4'd0) && (r_pos >= POS_W'(4))) begin
                    n_dvr = r_dvr >> 4;
                    n_pos = r_pos - POS_W'(4);
                end else begin
                    n_state = S_LOOP;
                end
            end

            // Another digit while a remainder is left and positions remain.
            S_LOOP: begin
                if ((r_rem != '0) && !r_pos[POS_W-1]) begin
                    n_state = S_NORM;
                end else begin
                    n_state = S_RND;
                end
            end

            // Normalize the remainder one bit a cycle, never past bit position zero.
            S_NORM: begin
                if (!r_rem[DATA_W-1] && (r_pos != '0)) begin
                    n_rem = r_rem << 1;
                    n_pos = r_pos - POS_W'(1);
                end else begin
                    n_hi    = '0;
                    n_lo    = r_rem;
                    n_opnd  = r_dvr;
                    n_cnt   = '0;
                    n_state = S_DSTEP;
                end
            end

            S_DSTEP: begin
                n_hi  = div_hi;
                n_lo  = div_lo;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_ACC;
                end
            end

            // Add the digit at its position; a digit that does not fit is overflow.
            S_ACC: begin
                if (digit_ovf) begin
                    n_done       = 1'b1;
                    n_rsp.result = OVF_VALUE;
                    n_rsp.status = ST_OVF;
                    n_state      = S_IDLE;
                end else begin
                    n_quo   = r_quo + digit_sh;
                    n_rem   = {r_hi[DATA_W-2:0], 1'b0};
                    n_pos   = r_pos - POS_W'(1);
                    n_state = S_LOOP;
                end
            end

            // The lowest quotient bit is the half bit used for rounding.
            S_RND: begin
                n_quo   = r_quo + DATA_W'(r_round);
                n_state = S_FIN;
            end

            S_FIN: begin
                n_done       = 1'b1;
                n_rsp.result = r_neg ? (DATA_W'(0) - quo_half) : quo_half;
                n_rsp.status = ST_OK;
                n_state      = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_round   <= 1'b1;
            r_ovf_chk <= 1'b1;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROUND: r_round   <= i_cfg_wdata[0];
                    CFG_OVF:   r_ovf_chk <= i_cfg_wdata[0];
                endcase
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_opnd <= n_opnd;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_dvr  <= n_dvr;
        r_quo  <= n_quo;
        r_pos  <= n_pos;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_rsp  <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Accepted requests by kind, and strobed responses with special statuses.
    assign req_take  = start && !busy;
    assign req_quick = req_take && (i_req.req_type != OP_MUL) && (i_req.req_type != OP_DIV);
    assign req_mul   = req_take && (i_req.req_type == OP_MUL);
    assign rsp_ovf   = o_done && (o_rsp.status == ST_OVF);
    assign rsp_divz  = o_done && (o_rsp.status == ST_DIVZ);

    // A single-cycle request answers in the next cycle.
    `Q16A_ASSERT_NEXT(a_quick_done, req_quick, o_done && !busy, "single-cycle request late")
    // A multiply request keeps the unit busy.
    `Q16A_ASSERT_NEXT(a_mul_busy, req_mul, busy && !o_done, "multiply did not start")
    // A response is never shown while the sequencer still works.
    `Q16A_ASSERT_SAME(a_done_idle, o_done, !busy, "response raised while busy")
    // Special statuses carry their fixed result values.
    `Q16A_ASSERT_SAME(a_ovf_value, rsp_ovf, o_rsp.result == OVF_VALUE, "overflow result wrong")
    `Q16A_ASSERT_SAME(a_divz_value, rsp_divz, o_rsp.result == DIVZ_VALUE, "div-by-zero result wrong")
    // Digit accumulation only happens at a legal bit position.
    `Q16A_ASSERT_SAME(a_pos_range, r_state == S_ACC, r_pos <= POS_INIT, "digit position out of range")

endmodule
